// ===== hw/rtl/four_band_tone_chord_decoder_assert.svh =====
// Assertion macros for the four-band tone chord decoder.
`ifndef FOUR_BAND_TONE_CHORD_DECODER_ASSERT_SVH
`define FOUR_BAND_TONE_CHORD_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/ftcd_pkg.sv =====
// Shared constants, types and helpers of the four-band tone chord decoder.
`timescale 1ns / 1ps
`default_nettype none

package ftcd_pkg;

   // Field widths
   localparam int FREQ_W     = 20;
   localparam int NUM_BANDS  = 4;
   localparam int NUM_LANES  = 4;
   localparam int TONE_W     = 4;
   localparam int WORD_W     = NUM_LANES * TONE_W;
   localparam int REQ_W      = NUM_LANES * FREQ_W;
   localparam int CSR_ADDR_W = 3;

   // Datapath widths
   localparam int STEP_W = 17;              // floor((2^20-1)/15) fits in 17 bits
   localparam int OFF_W  = FREQ_W + 1;      // signed f - low
   localparam int NUM_W  = FREQ_W + 2;      // 2*off + step
   localparam int PROD_W = STEP_W + TONE_W; // idx * step
   localparam int DIFF_W = PROD_W + 2;      // signed off - idx*step

   // Pipeline depth of a lane: front, setup, one stage per quotient bit, check, hit
   localparam int LANE_STAGES = TONE_W + 4;

   // Detection tolerance, Q16.4 Hz
   localparam int TOLERANCE = 800;

   localparam logic [TONE_W-1:0] TONE_MAX = TONE_W'(15);

   // Divide by 15 through a reciprocal: exact for all 20-bit spans
   localparam int               RECIP_SHIFT = 23;
   localparam logic [FREQ_W-1:0] RECIP_15   = FREQ_W'(559241);

   // Register address decode: bit 0 picks low or high edge, upper bits the band
   localparam logic CSR_SEL_LOW  = 1'b0;
   localparam logic CSR_SEL_HIGH = 1'b1;

   // Reset band edges, band 0 in the lowest element
   localparam logic [NUM_BANDS-1:0][FREQ_W-1:0] BAND_LOW_RST =
      {20'd112000, 20'd80000, 20'd48000, 20'd16000};
   localparam logic [NUM_BANDS-1:0][FREQ_W-1:0] BAND_HIGH_RST =
      {20'd136000, 20'd104000, 20'd72000, 20'd40000};

   typedef struct packed {
      logic [FREQ_W-1:0] low;
      logic [FREQ_W-1:0] high;
      logic [STEP_W-1:0] step;
   } band_cfg_type;

   typedef band_cfg_type [NUM_BANDS-1:0] band_tbl_type;

   // What one lane found for its frequency in every band
   typedef struct packed {
      logic [NUM_BANDS-1:0]             hit;
      logic [NUM_BANDS-1:0][TONE_W-1:0] tone;
   } lane_res_type;

   function automatic logic [STEP_W-1:0] div15(input logic [FREQ_W-1:0] x);
      logic [2*FREQ_W-1:0] prod;
      prod = {{FREQ_W{1'b0}}, x} * {{FREQ_W{1'b0}}, RECIP_15};
      return prod[RECIP_SHIFT +: STEP_W];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ftcd_band_regs.sv =====
// Band edge registers and the derived tone step of each band.
`timescale 1ns / 1ps
`default_nettype none

module ftcd_band_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ftcd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ftcd_pkg::FREQ_W-1:0]     csr_wdata,
   output ftcd_pkg::band_tbl_type          bands
);
   import ftcd_pkg::*;

   logic [NUM_BANDS-1:0][FREQ_W-1:0] low_ff;
   logic [NUM_BANDS-1:0][FREQ_W-1:0] high_ff;
   logic [NUM_BANDS-1:0][STEP_W-1:0] step_ff;
   logic [NUM_BANDS-1:0][STEP_W-1:0] step_in;
   logic [FREQ_W-1:0]                span;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= BAND_LOW_RST;
         high_ff <= BAND_HIGH_RST;
      end else if (csr_we) begin
         unique case (csr_addr[0])
            CSR_SEL_LOW:  low_ff[csr_addr[CSR_ADDR_W-1:1]]  <= csr_wdata;
            CSR_SEL_HIGH: high_ff[csr_addr[CSR_ADDR_W-1:1]] <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Step = floor(span / 15); an inverted band has span 0
   always_comb begin
      span = '0;
      for (int b = 0; b < NUM_BANDS; b++) begin
         span       = (high_ff[b] >= low_ff[b]) ? (high_ff[b] - low_ff[b]) : '0;
         step_in[b] = div15(span);
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         bands[b].low  = low_ff[b];
         bands[b].high = high_ff[b];
         bands[b].step = step_ff[b];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ftcd_lane.sv =====
// One decoding lane: matches a frequency against all bands in a pipeline.
`timescale 1ns / 1ps
`default_nettype none

module ftcd_lane #(
   parameter int TOLERANCE = ftcd_pkg::TOLERANCE
) (
   input  logic                             clock,
   input  logic [ftcd_pkg::LANE_STAGES-1:0] stage_en,
   input  logic [ftcd_pkg::FREQ_W-1:0]      freq,
   input  ftcd_pkg::band_tbl_type           bands,
   output ftcd_pkg::lane_res_type           res
);
   import ftcd_pkg::*;

   localparam logic [NUM_W-1:0]         TOL_N = NUM_W'(TOLERANCE);
   localparam logic signed [DIFF_W-1:0] TOL_D = DIFF_W'(TOLERANCE);

   typedef struct packed {
      logic signed [OFF_W-1:0] off;
      logic                    rng;
   } front_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] off;
      logic                    rng;
      logic                    zero;
      logic                    sat;
      logic [NUM_W-1:0]        rem;
      logic [TONE_W-1:0]       quo;
   } div_type;

   typedef struct packed {
      logic                     rng;
      logic [TONE_W-1:0]        idx;
      logic signed [DIFF_W-1:0] diff;
   } chk_type;

   front_type [NUM_BANDS-1:0]           front_ff, front_in;
   div_type   [NUM_BANDS-1:0][TONE_W:0] div_ff, div_in;
   chk_type   [NUM_BANDS-1:0]           chk_ff, chk_in;
   lane_res_type                        res_ff, res_in;

   // Front: offset from the lowest tone and the widened band window
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         front_in[b].off = $signed({1'b0, freq}) - $signed({1'b0, bands[b].low});
         front_in[b].rng = (({2'b0, freq} + TOL_N) >= {2'b0, bands[b].low}) &&
                           ({2'b0, freq} <= ({2'b0, bands[b].high} + TOL_N));
      end
   end

   // Setup: numerator 2*off + step, saturation when the quotient reaches 16;
   // then restoring division by 2*step, one quotient bit per stage, MSB first
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         div_in[b][0].off  = front_ff[b].off;
         div_in[b][0].rng  = front_ff[b].rng;
         div_in[b][0].zero = front_ff[b].off[OFF_W-1] || (front_ff[b].off == '0) ||
                             (bands[b].step == '0);
         div_in[b][0].rem  = {1'b0, front_ff[b].off[OFF_W-2:0], 1'b0} +
                             NUM_W'(bands[b].step);
         div_in[b][0].sat  = div_in[b][0].rem >= (NUM_W'(bands[b].step) << (TONE_W + 1));
         div_in[b][0].quo  = '0;
         for (int k = 1; k <= TONE_W; k++) begin
            div_in[b][k] = div_ff[b][k-1];
            if (div_ff[b][k-1].rem >= (NUM_W'(bands[b].step) << (TONE_W - k + 1))) begin
               div_in[b][k].rem = div_ff[b][k-1].rem -
                                  (NUM_W'(bands[b].step) << (TONE_W - k + 1));
               div_in[b][k].quo[TONE_W-k] = 1'b1;
            end
         end
      end
   end

   // Tone index and distance to the nominal tone frequency
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         chk_in[b].rng  = div_ff[b][TONE_W].rng;
         chk_in[b].idx  = div_ff[b][TONE_W].zero ? '0 :
                          div_ff[b][TONE_W].sat  ? TONE_MAX : div_ff[b][TONE_W].quo;
         chk_in[b].diff = DIFF_W'(div_ff[b][TONE_W].off) -
                          $signed({2'b0, PROD_W'(chk_in[b].idx) * PROD_W'(bands[b].step)});
      end
   end

   // Band accepts when inside the window and within tolerance of its tone
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         res_in.hit[b]  = chk_ff[b].rng && (chk_ff[b].diff >= -TOL_D) &&
                          (chk_ff[b].diff <= TOL_D);
         res_in.tone[b] = chk_ff[b].idx;
      end
   end

   // Stage registers, each held while it is full and its successor is full and stalled
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         front_ff <= front_in;
      end
      for (int k = 0; k <= TONE_W; k++) begin
         if (stage_en[k+1]) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
               div_ff[b][k] <= div_in[b][k];
            end
         end
      end
      if (stage_en[TONE_W+2]) begin
         chk_ff <= chk_in;
      end
      if (stage_en[TONE_W+3]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ftcd_merge.sv =====
// Merge stage: checks band order across lanes and builds the result word.
`timescale 1ns / 1ps
`default_nettype none

module ftcd_merge (
   input  logic                                            clock,
   input  logic                                            out_en,
   input  ftcd_pkg::lane_res_type [ftcd_pkg::NUM_LANES-1:0] lanes,
   output logic [ftcd_pkg::WORD_W-1:0]                     word,
   output logic                                            ok
);
   import ftcd_pkg::*;

   logic [NUM_LANES-1:0] lane_ok;
   logic [NUM_LANES-1:0] earlier;
   logic [WORD_W-1:0]    word_raw;
   logic [WORD_W-1:0]    word_in, word_ff;
   logic                 ok_in, ok_ff;

   // First accepting band must be the lane's own band
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         earlier[i] = 1'b0;
         for (int j = 0; j < i; j++) begin
            earlier[i] = earlier[i] | lanes[i].hit[j];
         end
         lane_ok[i]                 = lanes[i].hit[i] && !earlier[i];
         word_raw[i*TONE_W +: TONE_W] = lanes[i].tone[i];
      end
      ok_in   = &lane_ok;
      word_in = ok_in ? word_raw : '0;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (out_en) begin
         word_ff <= word_in;
         ok_ff   <= ok_in;
      end
   end

   assign word = word_ff;
   assign ok   = ok_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/four_band_tone_chord_decoder.sv =====
// Top level of the four-band tone chord decoder.
//
// Takes four measured tone frequencies (unsigned Q16.4 Hz) on the req_ stream and
// returns one 16-bit word plus an ok flag on the rsp_ stream. Each frequency is
// matched in its own lane against four tone bands; a band splits its span into
// sixteen tones, and the first band that accepts the frequency must be the
// frequency's own position. The tone indices form the word's nibbles.
// Band edges are written through the csr_ port (index 2b = low, 2b+1 = high of
// band b). They are to be written only while no transfer is in flight; the
// block itself does not enforce this.
// Throughput: one item per cycle while rsp_tready is high; each lane is a
// pipeline (front, setup, four quotient-bit stages of the tone division, check,
// hit) ending in the output register.
// Reset clears all valid bits and loads the default band edges.
// When rsp_tready is low the results queue up in the pipeline, empty stages
// close up, and req_tready falls only once every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none
`include "four_band_tone_chord_decoder_assert.svh"

module four_band_tone_chord_decoder #(
   parameter int TOLERANCE = ftcd_pkg::TOLERANCE
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ftcd_pkg::REQ_W-1:0]      req_tdata,  // freq_a, freq_b, freq_c, freq_d
   // Result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ftcd_pkg::WORD_W-1:0]     rsp_tdata,  // word
   output logic                            rsp_tuser,  // ok
   // Register writes
   input  logic                            csr_we,
   input  logic [ftcd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ftcd_pkg::FREQ_W-1:0]     csr_wdata
);
   import ftcd_pkg::*;

   band_tbl_type                  bands;
   lane_res_type [NUM_LANES-1:0]  lane_res;
   logic [LANE_STAGES-1:0]        stage_vld_ff, stage_vld_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [LANE_STAGES:0]          space;

   ftcd_band_regs u_band_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .bands     (bands)
   );

   // One lane per input frequency
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      ftcd_lane #(
         .TOLERANCE (TOLERANCE)
      ) u_lane (
         .clock    (clock),
         .stage_en (space[LANE_STAGES-1:0]),
         .freq     (req_tdata[i*FREQ_W +: FREQ_W]),
         .bands    (bands),
         .res      (lane_res[i])
      );
   end

   ftcd_merge u_merge (
      .clock  (clock),
      .out_en (space[LANE_STAGES]),
      .lanes  (lane_res),
      .word   (rsp_tdata),
      .ok     (rsp_tuser)
   );

   // A stage may load when it is empty or its contents move on
   always_comb begin
      space[LANE_STAGES] = !rsp_vld_ff || rsp_tready;
      for (int k = LANE_STAGES - 1; k >= 0; k--) begin
         space[k] = !stage_vld_ff[k] || space[k+1];
      end
   end

   // Valid bits follow the data
   always_comb begin
      stage_vld_in[0] = space[0] ? req_tvalid : stage_vld_ff[0];
      for (int k = 1; k < LANE_STAGES; k++) begin
         stage_vld_in[k] = space[k] ? stage_vld_ff[k-1] : stage_vld_ff[k];
      end
      rsp_vld_in = space[LANE_STAGES] ? stage_vld_ff[LANE_STAGES-1] : rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   assign req_tready = space[0];
   assign rsp_tvalid = rsp_vld_ff;

   // Checks
   `ASSERT_IMPLIES(a_fail_word_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `ASSERT_IMPLIES(a_full_stall_blocks, clock, reset, (&stage_vld_ff) && rsp_vld_ff && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_transfer_enters, clock, reset, req_tvalid && req_tready, stage_vld_ff[0])

endmodule

`default_nettype wire
